// ----- rtl/hsort_pkg.sv -----
// ---------------------------------------------------------------------------
// hsort_pkg
// Shared types and constants for the heap sort engine and its sorting cells.
// ---------------------------------------------------------------------------
package hsort_pkg;

   // Element width and default number of cells.
   localparam int HSORT_DATA_W   = 32;
   localparam int HSORT_CAPACITY = 64;

   // Command broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                            load;   // insert value this cycle
      logic                            shift;  // move every entry one cell down
      logic signed [HSORT_DATA_W-1:0]  value;  // element being inserted
   } hsort_ctrl_type;

endpackage

// ----- rtl/hsort_cell.sv -----
// ---------------------------------------------------------------------------
// hsort_cell
// One cell of the sorting chain. It holds one element and a valid bit and
// takes part in ordered insertion and in the drain shift toward cell zero.
// ---------------------------------------------------------------------------
module hsort_cell
   import hsort_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  hsort_ctrl_type                 ctrl,
   // Neighbor on the low side (smaller elements).
   input  logic                           prev_le,
   input  logic                           prev_valid,
   input  logic signed [HSORT_DATA_W-1:0] prev_value,
   // Neighbor on the high side (larger elements).
   input  logic                           next_valid,
   input  logic signed [HSORT_DATA_W-1:0] next_value,
   // Own contents.
   output logic                           cell_le,
   output logic                           cell_valid,
   output logic signed [HSORT_DATA_W-1:0] cell_value
);

   logic                           valid_ff, valid_in;
   logic signed [HSORT_DATA_W-1:0] value_ff, value_in;

   // The stored element stays in place when it is not larger than the new one.
   assign cell_le    = valid_ff && (value_ff <= ctrl.value);
   assign cell_valid = valid_ff;
   assign cell_value = value_ff;

   // On insertion the first cell that is not kept takes the new element and
   // every cell above it takes its low neighbor's element. On a drain
   // transfer every cell takes its high neighbor's element.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.load) begin
         valid_in = valid_ff | prev_valid;
         if (!cell_le) begin
            value_in = prev_le ? ctrl.value : prev_value;
         end
      end else if (ctrl.shift) begin
         valid_in = next_valid;
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- rtl/heap_sort_engine_core.sv -----
// ---------------------------------------------------------------------------
// heap_sort_engine_core
// Collects a set of signed elements and returns them in ascending order.
// ---------------------------------------------------------------------------
// The engine keeps its elements in a row of CAPACITY cells, always in
// ascending order, so one input transfer is taken every cycle while loading:
// each cell compares its element with the new one in the same cycle and the
// larger entries move up one cell. The transfer marked with req_tlast is
// stored too and starts the drain, which presents cell zero on the result
// channel and shifts the row down by one cell per result transfer, so a set
// of n stored elements takes n result transfers while the input side is held off.
// An element that arrives while all cells are occupied is dropped and the
// overflow flag in rsp_tuser is raised on every result of that set. After
// the result marked with rsp_tlast the row is empty and the flag is clear.
// ---------------------------------------------------------------------------
module heap_sort_engine_core
   import hsort_pkg::*;
#(
   parameter int CAPACITY = HSORT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last element of the set
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // final_res
   output logic [0:0]  rsp_tuser    // [0] overflowed
);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type      state_ff, state_in;
   logic           drop_ff, drop_in;
   hsort_ctrl_type ctrl;
   logic           req_xfer, rsp_xfer, full;

   logic                           cell_le    [CAPACITY];
   logic                           cell_valid [CAPACITY];
   logic signed [HSORT_DATA_W-1:0] cell_value [CAPACITY];

   // Handshakes.
   assign req_tready = (state_ff == ST_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign full       = cell_valid[CAPACITY-1];

   // Commands for the cell row.
   assign ctrl.load  = req_xfer && !full;
   assign ctrl.shift = rsp_xfer;
   assign ctrl.value = req_tdata;

   // Result channel shows the smallest element held in cell zero.
   assign rsp_tvalid   = (state_ff == ST_DRAIN) && cell_valid[0];
   assign rsp_tdata    = cell_value[0];
   assign rsp_tlast    = !cell_valid[1];
   assign rsp_tuser[0] = drop_ff;

   // The row of cells; the ends are tied off as an always-kept low side and
   // an empty high side.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                           p_le, p_valid, n_valid;
      logic signed [HSORT_DATA_W-1:0] p_value, n_value;

      if (i == 0) begin : g_first
         assign p_le    = 1'b1;
         assign p_valid = 1'b1;
         assign p_value = ctrl.value;
      end else begin : g_inner
         assign p_le    = cell_le[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_value = cell_value[i-1];
      end

      if (i == CAPACITY-1) begin : g_end
         assign n_valid = 1'b0;
         assign n_value = cell_value[i];
      end else begin : g_mid
         assign n_valid = cell_valid[i+1];
         assign n_value = cell_value[i+1];
      end

      hsort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_le    (p_le),
         .prev_valid (p_valid),
         .prev_value (p_value),
         .next_valid (n_valid),
         .next_value (n_value),
         .cell_le    (cell_le[i]),
         .cell_valid (cell_valid[i]),
         .cell_value (cell_value[i])
      );
   end

   // Load and drain sequencing with the sticky overflow flag.
   always_comb begin
      state_in = state_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (full) begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer && rsp_tlast) begin
               state_in = ST_LOAD;
               drop_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
            drop_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         drop_ff  <= drop_in;
      end
   end

endmodule
